@@ rtl/efb_pkg.sv @@
// Package with the request and result types, codes and CRC helper of the Ethernet frame builder.
package efb_pkg;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_DATA  = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  localparam logic [1:0] KIND_PRE  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_PAD  = 2'd2;
  localparam logic [1:0] KIND_FCS  = 2'd3;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_FINAL = 32'hFFFF_FFFF;
  localparam logic [7:0]  PREAMBLE_BYTE = 8'h55;
  localparam logic [7:0]  SFD_BYTE      = 8'hD5;
  localparam logic [2:0]  SFD_STEP      = 3'd7;
  localparam logic [1:0]  FCS_LAST_STEP = 2'd3;
  localparam logic [5:0]  PAD_MAX       = 6'd60;
  localparam logic [7:0]  MIN_LEN_RESET = 8'd60;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } req_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       last;
  } res_item_t;

  function automatic logic [31:0] crc_fold(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/ethernet_frame_builder_unit.sv @@
// Top level of the Ethernet frame builder: request sequencer, CRC-32 and result register.
//
// Requests arrive on the req channel (req_valid, req_ready, req_item) and line bytes
// leave on the res channel (res_valid, res_ready, res_item), one byte per transaction.
// A start request yields eight bytes (preamble and delimiter), a data request of an
// open frame yields its byte, and an end request yields the zero pad bytes followed
// by the four FCS bytes, the last one flagged. Other requests yield nothing.
// The sequencer produces one result byte per cycle into the result register unless
// the receiver stalls it. A request is first captured into the request registers, and
// its bytes then go into the result register. A request with no result leaves the
// sequencer idle. Data bytes stream at one per cycle unless the receiver stalls; the
// next request is taken in the cycle that the current one hands over its final byte.
// The cfg channel writes the minimum frame length; it is always ready. It is to be
// written only while the block is idle; the block itself does not enforce this. Reset
// sets the minimum length to 60, clears the frame state and drops any pending result.
// When the receiver holds res_ready low, the result register holds its byte, the
// sequencer stops, and req_ready falls once the current request still has bytes left.
module ethernet_frame_builder_unit
  import efb_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 16383
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req_item,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int CountW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CmpW = (CountW > 8) ? CountW : 8;
  localparam logic [CountW-1:0] CountMax = CountW'(MAX_FRAME_BYTES);

  logic [7:0]        min_frame_len;
  logic [31:0]       crc_reg;
  logic [31:0]       crc_next;
  logic [CountW-1:0] byte_count;
  logic [CountW-1:0] byte_count_next;
  logic              frame_open;

  logic              busy;
  logic [1:0]        cur_req;
  logic [7:0]        cur_data;
  logic [2:0]        step;
  logic              first;
  logic [5:0]        pad_left;
  logic [5:0]        pad_left_next;

  logic              req_take;
  logic              emit;
  logic              fin;
  logic              take_item;
  res_item_t         res_next;
  logic [5:0]        pad_calc;
  logic [5:0]        pad_eff;
  logic [CmpW-1:0]   diff;
  logic [31:0]       fcs;

  assign cfg_ready = 1'b1;
  assign emit = busy && (!res_valid || res_ready);
  assign req_ready = !busy || (emit && fin);
  assign req_take = req_valid && req_ready;
  assign take_item = (req_item.req_type == REQ_START) ||
                     (((req_item.req_type == REQ_DATA) || (req_item.req_type == REQ_END)) &&
                      frame_open);
  assign fcs = crc_reg ^ CRC_FINAL;

  always_comb begin
    diff = CmpW'(min_frame_len) - CmpW'(byte_count);
    if (CmpW'(byte_count) >= CmpW'(min_frame_len)) begin
      pad_calc = 6'd0;
    end else if (diff[7:0] > 8'(PAD_MAX)) begin
      pad_calc = PAD_MAX;
    end else begin
      pad_calc = diff[5:0];
    end
    pad_eff = first ? pad_calc : pad_left;
  end

  always_comb begin
    res_next = '0;
    fin = 1'b0;
    crc_next = crc_reg;
    byte_count_next = byte_count;
    pad_left_next = pad_eff;
    unique case (cur_req)
      REQ_START: begin
        res_next.out_byte = (step == SFD_STEP) ? SFD_BYTE : PREAMBLE_BYTE;
        res_next.byte_kind = KIND_PRE;
        fin = (step == SFD_STEP);
        if (fin) begin
          crc_next = CRC_INIT;
          byte_count_next = '0;
        end
      end
      REQ_DATA: begin
        res_next.out_byte = cur_data;
        res_next.byte_kind = KIND_DATA;
        fin = 1'b1;
        crc_next = crc_fold(crc_reg, cur_data);
        if (byte_count < CountMax) begin
          byte_count_next = byte_count + 1'b1;
        end
      end
      REQ_END: begin
        if (pad_eff != 6'd0) begin
          res_next.out_byte = 8'd0;
          res_next.byte_kind = KIND_PAD;
          pad_left_next = pad_eff - 1'b1;
          crc_next = crc_fold(crc_reg, 8'd0);
          if (byte_count < CountMax) begin
            byte_count_next = byte_count + 1'b1;
          end
        end else begin
          res_next.out_byte = fcs[{step[1:0], 3'b000} +: 8];
          res_next.byte_kind = KIND_FCS;
          res_next.last = (step[1:0] == FCS_LAST_STEP);
          fin = res_next.last;
        end
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame_len <= MIN_LEN_RESET;
      crc_reg <= CRC_INIT;
      byte_count <= '0;
      frame_open <= 1'b0;
      busy <= 1'b0;
      res_valid <= 1'b0;
      step <= '0;
      first <= 1'b0;
      pad_left <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_frame_len <= cfg_data;
      end
      if (emit) begin
        res_valid <= 1'b1;
        crc_reg <= crc_next;
        byte_count <= byte_count_next;
        pad_left <= pad_left_next;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (req_take) begin
        busy <= take_item;
        step <= '0;
        first <= 1'b1;
        if (req_item.req_type == REQ_START) begin
          frame_open <= 1'b1;
        end else if (req_item.req_type == REQ_END) begin
          frame_open <= 1'b0;
        end
      end else if (emit) begin
        first <= 1'b0;
        if (!(cur_req == REQ_END && pad_eff != 6'd0)) begin
          step <= step + 1'b1;
        end
        if (fin) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_item <= res_next;
    end
    if (req_take) begin
      cur_req <= req_item.req_type;
      cur_data <= req_item.data_byte;
    end
  end

endmodule
